/* design/bilinear_frame_downscaler_core_defines.svh */
// Assertion macros for the bilinear frame downscaler core.
// Used by the top level only; no other dependencies.
`ifndef BILINEAR_FRAME_DOWNSCALER_CORE_DEFINES_SVH
`define BILINEAR_FRAME_DOWNSCALER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BFD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define BFD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BFD_ASSERT_IMP(label, ante, cons, msg)
`define BFD_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

/* design/bfd_pkg.sv */
// Shared types, constants and the sample-position function of the downscaler.
// No dependencies.
package bfd_pkg;

  localparam int unsigned DestSize = 256;
  localparam int unsigned SizeW    = 12;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned OutW     = 16;
  localparam int unsigned WgtW     = 9;
  localparam int unsigned DestW    = 9;
  localparam int unsigned MaxSrcH  = 2048;
  localparam logic [0:0] RegWidth  = 1'b0;
  localparam logic [0:0] RegHeight = 1'b1;

  typedef struct packed {
    logic [SizeW-1:0] i0;
    logic [SizeW-1:0] i1;
    logic [WgtW-1:0]  w;
  } sample_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pixel_t;

  // Source position of destination index d over a source size n (9 fraction bits).
  function automatic sample_t sample(input logic [DestW-1:0] d, input logic [SizeW-1:0] n);
    logic [21:0]      s;
    logic [12:0]      a;
    logic [SizeW-1:0] nm1;
    sample_t          r;
    s   = 22'({d, 1'b1}) * 22'(n) - 22'd256;
    a   = s[21:9];
    nm1 = n - SizeW'(1);
    r.i0 = (a > 13'(nm1)) ? nm1 : a[SizeW-1:0];
    r.i1 = (13'(r.i0) + 13'd1 < 13'(nm1)) ? r.i0 + SizeW'(1) : nm1;
    r.w  = s[8:0];
    return r;
  endfunction

endpackage

/* design/bfd_if.sv */
// Handshake channels of the downscaler: source pixel requests and result requests.
// Depends on nothing but the field widths below.
interface bfd_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_blue;
  logic [7:0] pixel_green;
  logic [7:0] pixel_red;
  modport source (output valid, pixel_blue, pixel_green, pixel_red, input ready);
  modport sink (input valid, pixel_blue, pixel_green, pixel_red, output ready);
endinterface

interface bfd_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  dest_x;
  logic [7:0]  dest_y;
  logic [15:0] chan_blue;
  logic [15:0] chan_green;
  logic [15:0] chan_red;
  logic        run_last;
  logic        frame_done;
  modport source (output valid, dest_x, dest_y, chan_blue, chan_green, chan_red,
                  run_last, frame_done, input ready);
  modport sink (input valid, dest_x, dest_y, chan_blue, chan_green, chan_red,
                run_last, frame_done, output ready);
endinterface

/* design/bilinear_frame_downscaler_core.sv */
// Channel     | dir | payload
// pix_in      | in  | pixel_blue, pixel_green, pixel_red (8 bit each)
// res_out     | out | dest_x, dest_y, chan_blue/green/red (16 bit), run_last, frame_done
// cfg_*       | in  | cfg_idx_i selects source_width or source_height, cfg_wdata_i 12 bit
//
// One source pixel at a time: the accept cycle, a store read, four candidate tests and
// four select steps, plus three multiply stages and an output state per result and any
// res_out stall, then the destination column advance (at line end also the destination
// row advance).
// The line store is one synchronous RAM read at accept and written back in the next cycle.
// No clearing pass after reset; stalls on res_out hold the block.
// Depends on bfd_pkg, bfd_if and the defines header.
`include "bilinear_frame_downscaler_core_defines.svh"

module bilinear_frame_downscaler_core #(
  parameter int unsigned MAX_SOURCE_WIDTH = 2048
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  bfd_pixel_if.sink                  pix_in,
  bfd_result_if.source               res_out,
  input  logic                       cfg_we_i,
  input  logic [0:0]                 cfg_idx_i,
  input  logic [bfd_pkg::SizeW-1:0]  cfg_wdata_i
);

  localparam int unsigned CW = $clog2(MAX_SOURCE_WIDTH);
  localparam int unsigned RW = $clog2(bfd_pkg::MaxSrcH);
  localparam logic [13:0] MaxW = 14'(MAX_SOURCE_WIDTH);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_READ = 4'd1;
  localparam logic [3:0] S_CHK  = 4'd2;
  localparam logic [3:0] S_SEL  = 4'd3;
  localparam logic [3:0] S_M1   = 4'd4;
  localparam logic [3:0] S_M2   = 4'd5;
  localparam logic [3:0] S_M3   = 4'd6;
  localparam logic [3:0] S_OUT  = 4'd7;
  localparam logic [3:0] S_ADVC = 4'd8;
  localparam logic [3:0] S_ADVR = 4'd9;

  logic [3:0] state_q, state_d;
  logic [bfd_pkg::SizeW-1:0] width_q, height_q;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [bfd_pkg::DestW-1:0] ndc_q, ndc_d, ndr_q, ndr_d;
  logic [1:0] k_q, k_d;
  logic [3:0] hit_q, hit_d;
  bfd_pkg::pixel_t pix_q, left_q, above_left_q, above;
  logic [23:0] mem_rdata_q;
  logic [23:0] row_store [MAX_SOURCE_WIDTH];
  logic out_valid_q, out_valid_d;

  // clamped sizes
  logic [13:0] w_lo, h_lo;
  logic [bfd_pkg::SizeW-1:0] sw, sh;
  assign w_lo = (14'(width_q) < 14'd256) ? 14'd256 : 14'(width_q);
  assign h_lo = (14'(height_q) < 14'd256) ? 14'd256 : 14'(height_q);
  assign sw   = (w_lo > MaxW) ? MaxW[bfd_pkg::SizeW-1:0] : w_lo[bfd_pkg::SizeW-1:0];
  assign sh   = (h_lo > 14'd2048) ? 12'd2048 : h_lo[bfd_pkg::SizeW-1:0];
  assign above = mem_rdata_q;

  // candidate k: dy = k[1], dx = k[0]
  logic [bfd_pkg::DestW-1:0] cx, cy;
  bfd_pkg::sample_t smx, smy, adv_s;
  logic cand_hit, xeq, yeq;
  assign cx  = ndc_q + bfd_pkg::DestW'(k_q[0]);
  assign cy  = ndr_q + bfd_pkg::DestW'(k_q[1]);
  assign smx = bfd_pkg::sample(cx, sw);
  assign smy = bfd_pkg::sample(cy, sh);
  assign cand_hit = (cx < 9'd256) && (cy < 9'd256) &&
                    (14'(smx.i1) == 14'(col_q)) && (14'(smy.i1) == 14'(row_q));
  assign xeq = (smx.i0 == smx.i1);
  assign yeq = (smy.i0 == smy.i1);
  assign adv_s = (state_q == S_ADVR) ? bfd_pkg::sample(ndr_q, sh)
                                     : bfd_pkg::sample(ndc_q, sw);

  // blend operands and pipeline
  bfd_pkg::pixel_t p00_q, p01_q, p10_q, p11_q;
  logic [bfd_pkg::WgtW-1:0] wx_q, wy_q;
  logic [7:0] ox_q, oy_q;
  logic last_q, done_q;
  logic [16:0] top_q [3], bot_q [3];
  logic [25:0] v_q [3];
  logic [15:0] ch_q [3];

  function automatic logic [7:0] chn(input bfd_pkg::pixel_t p, input int unsigned i);
    logic [7:0] r;
    unique case (i)
      0: r = p.blue;
      1: r = p.green;
      default: r = p.red;
    endcase
    return r;
  endfunction

  assign pix_in.ready = (state_q == S_IDLE);
  logic in_acc;
  assign in_acc = pix_in.valid && pix_in.ready;

  always_comb begin
    state_d = state_q;
    col_d = col_q;
    row_d = row_q;
    ndc_d = ndc_q;
    ndr_d = ndr_q;
    k_d = k_q;
    hit_d = hit_q;
    out_valid_d = out_valid_q;
    unique case (state_q)
      S_IDLE: if (in_acc) state_d = S_READ;
      S_READ: begin
        k_d = 2'd0;
        state_d = S_CHK;
      end
      S_CHK: begin
        hit_d[k_q] = cand_hit;
        k_d = k_q + 2'd1;
        if (k_q == 2'd3) state_d = S_SEL;
      end
      S_SEL: begin
        if (hit_q[k_q]) state_d = S_M1;
        else if (k_q == 2'd3) state_d = S_ADVC;
        else k_d = k_q + 2'd1;
      end
      S_M1: state_d = S_M2;
      S_M2: state_d = S_M3;
      S_M3: begin
        out_valid_d = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (res_out.ready) begin
          out_valid_d = 1'b0;
          if (k_q == 2'd3) state_d = S_ADVC;
          else begin
            k_d = k_q + 2'd1;
            state_d = S_SEL;
          end
        end
      end
      S_ADVC: begin
        if (ndc_q < 9'd256 && 14'(adv_s.i1) <= 14'(col_q)) ndc_d = ndc_q + 9'd1;
        else if (14'(col_q) + 14'd1 >= 14'(sw)) begin
          col_d = '0;
          ndc_d = '0;
          state_d = S_ADVR;
        end else begin
          col_d = col_q + CW'(1);
          state_d = S_IDLE;
        end
      end
      S_ADVR: begin
        if (ndr_q < 9'd256 && 14'(adv_s.i1) <= 14'(row_q)) ndr_d = ndr_q + 9'd1;
        else begin
          if (14'(row_q) + 14'd1 >= 14'(sh)) begin
            row_d = '0;
            ndr_d = '0;
          end else begin
            row_d = row_q + RW'(1);
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      width_q <= 12'd256;
      height_q <= 12'd256;
      col_q <= '0;
      row_q <= '0;
      ndc_q <= '0;
      ndr_q <= '0;
      k_q <= '0;
      hit_q <= '0;
      out_valid_q <= 1'b0;
      left_q <= '0;
      above_left_q <= '0;
    end else begin
      state_q <= state_d;
      col_q <= col_d;
      row_q <= row_d;
      ndc_q <= ndc_d;
      ndr_q <= ndr_d;
      k_q <= k_d;
      hit_q <= hit_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == bfd_pkg::RegWidth) width_q <= cfg_wdata_i;
        else height_q <= cfg_wdata_i;
      end
      // shift the neighbor window once the results are out
      if (state_q == S_ADVC && state_d != S_ADVC) begin
        left_q <= pix_q;
        above_left_q <= above;
      end
    end
  end

  // line store: read at accept, write back the new pixel the next cycle
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mem_rdata_q <= row_store[col_q];
      pix_q <= {pix_in.pixel_red, pix_in.pixel_green, pix_in.pixel_blue};
    end
    if (state_q == S_READ) row_store[col_q] <= pix_q;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_SEL && hit_q[k_q]) begin
      p11_q <= pix_q;
      p10_q <= xeq ? pix_q : left_q;
      p01_q <= yeq ? pix_q : above;
      p00_q <= yeq ? (xeq ? pix_q : left_q) : (xeq ? above : above_left_q);
      wx_q <= smx.w;
      wy_q <= smy.w;
      ox_q <= cx[7:0];
      oy_q <= cy[7:0];
      done_q <= (cx == 9'd255) && (cy == 9'd255);
      last_q <= (hit_q >> (k_q + 2'd1)) == 4'd0 || k_q == 2'd3;
    end
    for (int i = 0; i < 3; i++) begin
      if (state_q == S_M1) begin
        top_q[i] <= 17'(18'(chn(p00_q, i)) * 18'(10'd512 - 10'(wx_q)) +
                        18'(chn(p01_q, i)) * 18'(wx_q));
        bot_q[i] <= 17'(18'(chn(p10_q, i)) * 18'(10'd512 - 10'(wx_q)) +
                        18'(chn(p11_q, i)) * 18'(wx_q));
      end
      if (state_q == S_M2) begin
        v_q[i] <= 26'(27'(top_q[i]) * 27'(10'd512 - 10'(wy_q)) +
                      27'(bot_q[i]) * 27'(wy_q));
      end
      if (state_q == S_M3) begin
        ch_q[i] <= 16'(((35'(v_q[i]) << 8) + 35'(v_q[i]) + 35'd131072) >> 18);
      end
    end
  end

  assign res_out.valid      = out_valid_q;
  assign res_out.dest_x     = ox_q;
  assign res_out.dest_y     = oy_q;
  assign res_out.chan_blue  = ch_q[0];
  assign res_out.chan_green = ch_q[1];
  assign res_out.chan_red   = ch_q[2];
  assign res_out.run_last   = last_q;
  assign res_out.frame_done = done_q;

  `BFD_ASSERT_IMP(a_one_side, pix_in.ready, !res_out.valid, "ready while result pending")
  `BFD_ASSERT_IMP(a_done_last, res_out.valid && res_out.frame_done, res_out.run_last, "frame end not last")
  `BFD_ASSERT_NXT(a_acc_read, pix_in.valid && pix_in.ready, state_q == S_READ, "no store read after accept")

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for bilinear_frame_downscaler_core: streams raster pixels and
// checks every result request against a built-in fixed-point predictor.
// Depends on bfd_pkg, the bfd_if interfaces and the core.

module tb_top;

  typedef struct packed {
    bit [7:0]  dest_x;
    bit [7:0]  dest_y;
    bit [15:0] chan_blue;
    bit [15:0] chan_green;
    bit [15:0] chan_red;
    bit        run_last;
    bit        frame_done;
  } dest_pixel_t;

  class downscale_scoreboard;
    bfd_pkg::pixel_t line_buf[2048];
    bfd_pkg::pixel_t left_px, above_left_px;
    int unsigned     src_col, src_row, dst_col, dst_row;
    int unsigned     width_reg, height_reg;
    dest_pixel_t     expected_q[$];
    int              mismatches, pixels_seen, results_seen, frames_seen;

    function new();
      foreach (line_buf[i]) line_buf[i] = '0;
      left_px = '0;
      above_left_px = '0;
      src_col = 0; src_row = 0; dst_col = 0; dst_row = 0;
      width_reg = 256; height_reg = 256;
    endfunction

    function void set_reg(logic [0:0] idx, bit [11:0] val);
      if (idx == bfd_pkg::RegWidth) width_reg = val;
      else height_reg = val;
    endfunction

    function int unsigned clamp_size(int unsigned v);
      if (v < 256) return 256;
      if (v > 2048) return 2048;
      return v;
    endfunction

    // Source position of destination index d over n source samples, 9 fraction bits.
    function void locate(int unsigned d, int unsigned n, output int unsigned i0,
                         output int unsigned i1, output int unsigned w);
      int unsigned s;
      s = (2 * d + 1) * n - 256;
      i0 = s >> 9;
      if (i0 > n - 1) i0 = n - 1;
      i1 = (i0 + 1 < n - 1) ? i0 + 1 : n - 1;
      w = s & 511;
    endfunction

    function bit [15:0] mix(bit [7:0] a00, bit [7:0] a01, bit [7:0] a10, bit [7:0] a11,
                            int unsigned wx, int unsigned wy);
      longint unsigned top, bot, v;
      top = longint'(a00) * (512 - wx) + longint'(a01) * wx;
      bot = longint'(a10) * (512 - wx) + longint'(a11) * wx;
      v = top * (512 - wy) + bot * wy;
      return 16'((v * 257 + (64'd1 << 17)) >> 18);
    endfunction

    function void note_pixel(bfd_pkg::pixel_t px);
      int unsigned     sw, sh, c, r, x, y, x0, x1, wx, y0, y1, wy;
      bfd_pkg::pixel_t above, p00, p01, p10, p11;
      dest_pixel_t     e;
      int              n;
      sw = clamp_size(width_reg);
      sh = clamp_size(height_reg);
      c = src_col;
      r = src_row;
      n = 0;
      pixels_seen++;
      above = line_buf[c];
      line_buf[c] = px;
      for (int dy = 0; dy < 2; dy++) begin
        y = dst_row + dy;
        if (y >= 256) break;
        locate(y, sh, y0, y1, wy);
        if (y1 != r) continue;
        for (int dx = 0; dx < 2; dx++) begin
          x = dst_col + dx;
          if (x >= 256) break;
          locate(x, sw, x0, x1, wx);
          if (x1 != c) continue;
          p11 = px;
          p10 = (x0 == x1) ? px : left_px;
          p01 = (y0 == y1) ? px : above;
          if (y0 == y1) p00 = p10;
          else p00 = (x0 == x1) ? above : above_left_px;
          e.dest_x = x[7:0];
          e.dest_y = y[7:0];
          e.chan_blue = mix(p00.blue, p01.blue, p10.blue, p11.blue, wx, wy);
          e.chan_green = mix(p00.green, p01.green, p10.green, p11.green, wx, wy);
          e.chan_red = mix(p00.red, p01.red, p10.red, p11.red, wx, wy);
          e.run_last = 1'b0;
          e.frame_done = (x == 255 && y == 255);
          if (e.frame_done) frames_seen++;
          expected_q.push_back(e);
          n++;
        end
      end
      if (n > 0) expected_q[expected_q.size() - 1].run_last = 1'b1;
      above_left_px = above;
      left_px = px;
      // advance destination column past every column already complete
      while (dst_col < 256) begin
        locate(dst_col, sw, x0, x1, wx);
        if (x1 > c) break;
        dst_col++;
      end
      if (c + 1 >= sw) begin
        src_col = 0;
        dst_col = 0;
        while (dst_row < 256) begin
          locate(dst_row, sh, y0, y1, wy);
          if (y1 > r) break;
          dst_row++;
        end
        if (r + 1 >= sh) begin
          src_row = 0;
          dst_row = 0;
        end else begin
          src_row = r + 1;
        end
      end else begin
        src_col = c + 1;
      end
    endfunction

    function void check_result(dest_pixel_t got);
      dest_pixel_t e;
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result x=%0d y=%0d", got.dest_x, got.dest_y);
        return;
      end
      e = expected_q.pop_front();
      if (got != e) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: result mismatch exp x=%0d y=%0d b=%h g=%h r=%h last=%b done=%b",
                   e.dest_x, e.dest_y, e.chan_blue, e.chan_green, e.chan_red,
                   e.run_last, e.frame_done);
          $display("       got x=%0d y=%0d b=%h g=%h r=%h last=%b done=%b",
                   got.dest_x, got.dest_y, got.chan_blue, got.chan_green, got.chan_red,
                   got.run_last, got.frame_done);
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [0:0] cfg_idx_i;
  logic [bfd_pkg::SizeW-1:0] cfg_wdata_i;
  int   gap_pct;
  int   stall_left;
  longint cycles = 0;

  bfd_pixel_if  pix ();
  bfd_result_if res ();

  downscale_scoreboard sb = new();

  bilinear_frame_downscaler_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_in      (pix),
    .res_out     (res),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll >= gap_pct) return 0;
    if (roll < gap_pct * 3 / 4) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Random receiver stalls, mostly short.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      res.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      res.ready <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  always @(posedge clk_i) begin
    dest_pixel_t got;
    if (rst_ni && pix.valid && pix.ready)
      sb.note_pixel('{red: pix.pixel_red, green: pix.pixel_green, blue: pix.pixel_blue});
    if (rst_ni && res.valid && res.ready) begin
      got.dest_x = res.dest_x;
      got.dest_y = res.dest_y;
      got.chan_blue = res.chan_blue;
      got.chan_green = res.chan_green;
      got.chan_red = res.chan_red;
      got.run_last = res.run_last;
      got.frame_done = res.frame_done;
      sb.check_result(got);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("timeout with %0d results outstanding", sb.expected_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_pixel(bit [7:0] b, bit [7:0] g, bit [7:0] r);
    int idle;
    idle = pick_gap();
    if (idle > 0) begin
      pix.valid <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    pix.valid <= 1'b1;
    pix.pixel_blue <= b;
    pix.pixel_green <= g;
    pix.pixel_red <= r;
    do @(posedge clk_i); while (!pix.ready);
  endtask

  task automatic send_random(int count);
    repeat (count) send_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                              $urandom_range(0, 255));
  endtask

  // Hold the sender until every expected result is out, then let the core settle.
  task automatic drain();
    pix.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, bit [11:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    gap_pct = 30;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = bfd_pkg::RegWidth;
    cfg_wdata_i = '0;
    pix.valid = 1'b0;
    pix.pixel_blue = '0;
    pix.pixel_green = '0;
    pix.pixel_red = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Narrow line with a clamped height register: the second row gives the first results.
    write_reg(bfd_pkg::RegWidth, 12'd300);
    write_reg(bfd_pkg::RegHeight, 12'h000);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'hFF, 8'h00, 8'h00);
    send_pixel(8'h00, 8'hFF, 8'h00);
    send_pixel(8'h00, 8'h00, 8'hFF);
    send_pixel(8'hAA, 8'h55, 8'hAA);
    send_pixel(8'h55, 8'hAA, 8'h55);
    send_pixel(8'h01, 8'h80, 8'hFE);
    send_random(292);
    send_random(40);
    drain();

    // Widen mid-line past the clamp, then narrow again so passed destinations get skipped.
    write_reg(bfd_pkg::RegWidth, 12'hFFF);
    send_random(20);
    drain();
    write_reg(bfd_pkg::RegWidth, 12'd300);
    send_random(20);
    drain();

    $display("covered %0d source pixels, %0d results, %0d frame ends",
             sb.pixels_seen, sb.results_seen, sb.frames_seen);
    $display("clamped height and width registers, mid-line width changes, random stalls");
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.expected_q.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule
